/* hw/rtl/mxrq_pkg.sv */
// mxrq_pkg: shared constants for the MX block requantiser (E2M1 codes, E8M0 scale).
// No dependencies; used by mx_block_requantize_e2m1_unit.
package mxrq_pkg;

    localparam int BLOCK_LENGTH = 32;
    localparam int ADDR_W       = (BLOCK_LENGTH > 1) ? $clog2(BLOCK_LENGTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(BLOCK_LENGTH - 1);

    localparam int MANT_W  = 32;
    localparam int EXP_W   = 10;
    localparam int ENTRY_W = MANT_W + EXP_W;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 16;

    localparam logic [3:0] SIGN_BIT = 4'h8;
    localparam logic [2:0] MAG_MAX  = 3'h7;

    localparam logic signed [7:0] SCALE_MIN  = -8'sd127;
    localparam logic signed [7:0] SCALE_MAX  = 8'sd127;
    localparam logic signed [7:0] SCALE_BIAS = 8'sd127;

    // Round a value held in quarter units of 2^(scale-1) (two times the half-unit
    // quotient plus sticky) to the E2M1 magnitude index, ties to the even code.
    function automatic logic [2:0] e2m1_index(input logic [6:0] h2);
        logic [2:0] idx;
        if (h2 <= 7'd2)       idx = 3'd0;
        else if (h2 <= 7'd5)  idx = 3'd1;
        else if (h2 <= 7'd10) idx = 3'd2;
        else if (h2 <= 7'd13) idx = 3'd3;
        else if (h2 <= 7'd20) idx = 3'd4;
        else if (h2 <= 7'd27) idx = 3'd5;
        else if (h2 <= 7'd40) idx = 3'd6;
        else                  idx = 3'd7;
        return idx;
    endfunction

endpackage

/* hw/rtl/mxrq_ram.sv */
// mxrq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mxrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/mx_block_requantize_e2m1_unit.sv */
// mx_block_requantize_e2m1_unit: MXFP4 block quantiser, shared E8M0 scale, E2M1 codes.
// Depends on mxrq_pkg and mxrq_ram.
//
// channel  dir  signals                 fields (low bit up)
// s_*      in   tvalid tready tdata[48] element_mantissa[32], elem_exp[10], pad
// m_*      out  tvalid tready tdata[16] fp4_code[4], e8m0_scale[8], element_saturated,
//                      tlast            scale_clamped, pad; tlast = last_of_block
//
// Load: each item passes accept, 5 steps of the shared right shifter and a max update;
// the last item of a block adds a scale clamp step.
// Emit: each result passes RAM read, unpack, up to 5 shifter steps and round, then
// waits while m_tready is low before the next result is read.
// s_tready is low for the whole emit phase of a block.
// rst_n clears the sequencer, load count and running maximum.
module mx_block_requantize_e2m1_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mxrq_pkg::IN_W-1:0]   s_tdata,   // element_mantissa, elem_exp
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mxrq_pkg::OUT_W-1:0]  m_tdata,   // fp4_code, e8m0_scale, saturated, clamped
    output logic                        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE, S_LNORM, S_LMAX, S_SCALE, S_ERD, S_ELOAD, S_ENORM, S_EFIN
    } state_t;

    localparam int AW = mxrq_pkg::ADDR_W;

    state_t                       state_reg,   state_next;
    logic                         eout_reg,    eout_next;
    logic [AW-1:0]                cnt_reg,     cnt_next;
    logic [AW-1:0]                idx_reg,     idx_next;
    logic [2:0]                   step_reg,    step_next;
    logic [31:0]                  w_reg,       w_next;
    logic                         sticky_reg,  sticky_next;
    logic [4:0]                   pos_reg,     pos_next;
    logic [4:0]                   rsh_reg,     rsh_next;
    logic signed [9:0]            exp_reg,     exp_next;
    logic                         neg_reg,     neg_next;
    logic                         nz_reg,      nz_next;
    logic signed [11:0]           max_reg,     max_next;
    logic                         empty_reg,   empty_next;
    logic signed [7:0]            scale_reg,   scale_next;
    logic                         clamped_reg, clamped_next;
    logic                         mvalid_reg,  mvalid_next;
    logic [3:0]                   code_reg,    code_next;
    logic                         sat_reg,     sat_next;
    logic                         last_reg,    last_next;

    logic                         ram_we;
    logic [mxrq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [mxrq_pkg::ENTRY_W-1:0] ram_rdata;

    logic signed [31:0]           in_m;
    logic [31:0]                  in_mag;
    logic signed [31:0]           rd_m;
    logic signed [9:0]            rd_e;
    logic [31:0]                  rd_mag;
    logic [4:0]                   sh_amt;
    logic [31:0]                  sh_out;
    logic                         sh_lost;
    logic [5:0]                   blen;
    logic                         over;
    logic signed [11:0]           req;
    logic signed [11:0]           k;
    logic [11:0]                  rneg;
    logic [6:0]                   h2;
    logic                         q_sat;
    logic [2:0]                   q_idx;

    mxrq_ram #(
        .WIDTH (mxrq_pkg::ENTRY_W),
        .DEPTH (mxrq_pkg::BLOCK_LENGTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tlast   = last_reg;
    assign m_tdata   = {2'b00, clamped_reg, sat_reg,
                        8'(scale_reg + mxrq_pkg::SCALE_BIAS), code_reg};

    assign in_m      = s_tdata[31:0];
    assign in_mag    = in_m[31] ? 32'(-in_m) : 32'(in_m);
    assign ram_we    = s_tvalid && s_tready;
    assign ram_wdata = s_tdata[mxrq_pkg::ENTRY_W-1:0];

    assign rd_m      = ram_rdata[31:0];
    assign rd_e      = ram_rdata[41:32];
    assign rd_mag    = rd_m[31] ? 32'(-rd_m) : 32'(rd_m);

    // shared shift unit: right shift by 16, 8, 4, 2, 1 with sticky
    assign sh_amt    = 5'(5'd16 >> step_reg);
    assign sh_out    = w_reg >> sh_amt;
    assign sh_lost   = |(w_reg & ((32'd1 << sh_amt) - 32'd1));

    assign blen      = (w_reg[31:1] != 31'd0) ? ({1'b0, pos_reg} + 6'd2) : 6'd1;
    assign over      = w_reg[1] & w_reg[0] & sticky_reg;
    assign req       = {{2{exp_reg[9]}}, exp_reg} + {6'd0, blen} - 12'sd3
                       + {11'd0, over};

    assign k         = {{2{rd_e[9]}}, rd_e} - {{4{scale_reg[7]}}, scale_reg} + 12'sd2;
    assign rneg      = 12'(-k);

    assign h2        = {w_reg[5:0], sticky_reg};
    assign q_sat     = (w_reg[31:6] != 26'd0) || (h2 > 7'd48);
    assign q_idx     = mxrq_pkg::e2m1_index(h2);

    always_comb
    begin
        state_next   = state_reg;
        eout_next    = eout_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        w_next       = w_reg;
        sticky_next  = sticky_reg;
        pos_next     = pos_reg;
        rsh_next     = rsh_reg;
        exp_next     = exp_reg;
        neg_next     = neg_reg;
        nz_next      = nz_reg;
        max_next     = max_reg;
        empty_next   = empty_reg;
        scale_next   = scale_reg;
        clamped_next = clamped_reg;
        mvalid_next  = mvalid_reg;
        code_next    = code_reg;
        sat_next     = sat_reg;
        last_next    = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    w_next      = in_mag;
                    sticky_next = 1'b0;
                    pos_next    = 5'd0;
                    step_next   = 3'd0;
                    exp_next    = s_tdata[41:32];
                    nz_next     = (in_mag != 32'd0);
                    state_next  = S_LNORM;
                end
            end
            S_LNORM:
            begin
                // find top two bits: keep shifting while at least two bits remain
                if (sh_out[31:1] != 31'd0)
                begin
                    w_next      = sh_out;
                    sticky_next = sticky_reg | sh_lost;
                    pos_next    = pos_reg + sh_amt;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = S_LMAX;
                end
            end
            S_LMAX:
            begin
                if (nz_reg && (empty_reg || (req > max_reg)))
                begin
                    max_next   = req;
                    empty_next = 1'b0;
                end
                if (cnt_reg == mxrq_pkg::LAST_IDX)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    cnt_next   = cnt_reg + AW'(1);
                    state_next = S_IDLE;
                end
            end
            S_SCALE:
            begin
                clamped_next = 1'b0;
                if (empty_reg)
                begin
                    scale_next = 8'sd0;
                end
                else if (max_reg < 12'(mxrq_pkg::SCALE_MIN))
                begin
                    scale_next   = mxrq_pkg::SCALE_MIN;
                    clamped_next = 1'b1;
                end
                else if (max_reg > 12'(mxrq_pkg::SCALE_MAX))
                begin
                    scale_next   = mxrq_pkg::SCALE_MAX;
                    clamped_next = 1'b1;
                end
                else
                begin
                    scale_next = 8'(max_reg);
                end
                idx_next   = '0;
                state_next = S_ERD;
            end
            S_ERD:
            begin
                state_next = S_ELOAD;
            end
            S_ELOAD:
            begin
                neg_next    = rd_m[31];
                sticky_next = 1'b0;
                step_next   = 3'd0;
                state_next  = S_EFIN;
                if (!k[11])
                begin
                    if (rd_mag == 32'd0)
                    begin
                        w_next = 32'd0;
                    end
                    else if ((rd_mag[31:5] != 27'd0) || (k >= 12'sd5))
                    begin
                        w_next = '1;
                    end
                    else
                    begin
                        w_next = 32'(rd_mag[4:0]) << k[2:0];
                    end
                end
                else if (rneg >= 12'd32)
                begin
                    w_next      = 32'd0;
                    sticky_next = (rd_mag != 32'd0);
                end
                else
                begin
                    w_next     = rd_mag;
                    rsh_next   = rneg[4:0];
                    state_next = S_ENORM;
                end
            end
            S_ENORM:
            begin
                if (rsh_reg[3'd4 - step_reg])
                begin
                    w_next      = sh_out;
                    sticky_next = sticky_reg | sh_lost;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = S_EFIN;
                end
            end
            S_EFIN:
            begin
                if (!eout_reg)
                begin
                    sat_next    = q_sat;
                    if (q_sat)
                    begin
                        code_next = {neg_reg, mxrq_pkg::MAG_MAX};
                    end
                    else if (q_idx == 3'd0)
                    begin
                        code_next = 4'h0;
                    end
                    else
                    begin
                        code_next = {neg_reg, q_idx};
                    end
                    last_next   = (idx_reg == mxrq_pkg::LAST_IDX);
                    mvalid_next = 1'b1;
                    eout_next   = 1'b1;
                end
                else if (m_tready)
                begin
                    mvalid_next = 1'b0;
                    eout_next   = 1'b0;
                    if (last_reg)
                    begin
                        cnt_next   = '0;
                        empty_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            eout_reg    <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            step_reg    <= 3'd0;
            w_reg       <= 32'd0;
            sticky_reg  <= 1'b0;
            pos_reg     <= 5'd0;
            rsh_reg     <= 5'd0;
            exp_reg     <= 10'sd0;
            neg_reg     <= 1'b0;
            nz_reg      <= 1'b0;
            max_reg     <= 12'sd0;
            empty_reg   <= 1'b1;
            scale_reg   <= 8'sd0;
            clamped_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
            code_reg    <= 4'h0;
            sat_reg     <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            eout_reg    <= eout_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            w_reg       <= w_next;
            sticky_reg  <= sticky_next;
            pos_reg     <= pos_next;
            rsh_reg     <= rsh_next;
            exp_reg     <= exp_next;
            neg_reg     <= neg_next;
            nz_reg      <= nz_next;
            max_reg     <= max_next;
            empty_reg   <= empty_next;
            scale_reg   <= scale_next;
            clamped_reg <= clamped_next;
            mvalid_reg  <= mvalid_next;
            code_reg    <= code_next;
            sat_reg     <= sat_next;
            last_reg    <= last_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |-> (m_tdata[2:0] == mxrq_pkg::MAG_MAX))
        else $error("saturated item without top magnitude");

    a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] != mxrq_pkg::SIGN_BIT))
        else $error("negative zero emitted");

    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && cnt_reg == '0 && empty_reg))
        else $error("block state not cleared after last item");

    a_scale_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> $stable(scale_reg) && $stable(clamped_reg))
        else $error("shared scale changed inside a block");

endmodule
